// ===== rtl/pid3_pkg.sv =====
// ----------------------------------------------------------------------------
// pid3_pkg
// Shared types, constants, microcode table and helpers for the three-axis PID
// controller.
// ----------------------------------------------------------------------------
package pid3_pkg;

    // Default number of control loops
    localparam int AXES_DEF = 3;

    // Field widths
    localparam int AXIS_W  = 2;
    localparam int DATA_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int GAINS_W = 48;
    localparam int LIM_W   = 11;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int DIFF_W  = DATA_W + 1;      // setpoint - measurement
    localparam int MA_W    = 35;              // multiplier operand A, signed
    localparam int MB_W    = GAIN_W + 1;      // multiplier operand B, signed
    localparam int PROD_W  = MA_W + MB_W;     // 52
    localparam int INTEG_W = 32;              // integral, Q11.20
    localparam int ACC_W   = 60;              // drive sum, Q.20

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ILIM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OLIM   = 3'd6;

    // Register reset values
    localparam logic [GAINS_W-1:0] KP_RST     = 48'h0A00_0F00_0F00;
    localparam logic [GAINS_W-1:0] KI_RST     = 48'h0005_0005_0005 << 8;
    localparam logic [GAINS_W-1:0] KD_RST     = 48'h0003_0004_0004 << 8;
    localparam logic [DATA_W-1:0]  PERIOD_RST = 16'd262;
    localparam logic [DATA_W-1:0]  RATE_RST   = 16'd250;
    localparam logic [LIM_W-1:0]   ILIM_RST   = 11'd200;
    localparam logic [LIM_W-1:0]   OLIM_RST   = 11'd800;

    // Microcode fields
    localparam int STEP_W = 3;

    localparam logic [1:0] A_ERR  = 2'd0;
    localparam logic [1:0] A_DM   = 2'd1;
    localparam logic [1:0] A_PROD = 2'd2;

    localparam logic [2:0] B_KI   = 3'd0;
    localparam logic [2:0] B_KP   = 3'd1;
    localparam logic [2:0] B_KD   = 3'd2;
    localparam logic [2:0] B_PER  = 3'd3;
    localparam logic [2:0] B_RATE = 3'd4;

    localparam logic [2:0] ALU_NOP   = 3'd0;
    localparam logic [2:0] ALU_DIFF  = 3'd1;
    localparam logic [2:0] ALU_INTEG = 3'd2;
    localparam logic [2:0] ALU_ADD   = 3'd3;
    localparam logic [2:0] ALU_SUB   = 3'd4;
    localparam logic [2:0] ALU_OUT   = 3'd5;

    localparam logic [STEP_W-1:0] STEP_OUT = 3'd7;

    // One control word
    typedef struct packed {
        logic              mul_en;
        logic [1:0]        a_sel;
        logic [2:0]        b_sel;
        logic [2:0]        alu_op;
        logic              jmp_bad;   // jump when the axis has no loop
        logic [STEP_W-1:0] jmp_tgt;
        logic              last;
    } ctrl_t;

    // Control word plus sequencer qualifiers handed to the datapath
    typedef struct packed {
        ctrl_t word;
        logic  step_en;
        logic  axis_ok;
    } dp_ctl_t;

    function automatic ctrl_t mk(input logic mul_en, input logic [1:0] a_sel,
                                 input logic [2:0] b_sel, input logic [2:0] alu_op,
                                 input logic jmp_bad, input logic last);
        ctrl_t w;
        w.mul_en  = mul_en;
        w.a_sel   = a_sel;
        w.b_sel   = b_sel;
        w.alu_op  = alu_op;
        w.jmp_bad = jmp_bad;
        w.jmp_tgt = STEP_OUT;
        w.last    = last;
        return w;
    endfunction

    // Program: one control word per step
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        case (step)
            3'd0:    w = mk(1'b0, A_ERR,  B_KI,   ALU_DIFF,  1'b1, 1'b0);
            3'd1:    w = mk(1'b1, A_ERR,  B_KI,   ALU_NOP,   1'b0, 1'b0);
            3'd2:    w = mk(1'b1, A_PROD, B_PER,  ALU_NOP,   1'b0, 1'b0);
            3'd3:    w = mk(1'b1, A_ERR,  B_KP,   ALU_INTEG, 1'b0, 1'b0);
            3'd4:    w = mk(1'b1, A_DM,   B_RATE, ALU_ADD,   1'b0, 1'b0);
            3'd5:    w = mk(1'b1, A_PROD, B_KD,   ALU_NOP,   1'b0, 1'b0);
            3'd6:    w = mk(1'b0, A_ERR,  B_KI,   ALU_SUB,   1'b0, 1'b0);
            3'd7:    w = mk(1'b0, A_ERR,  B_KI,   ALU_OUT,   1'b0, 1'b1);
            default: w = mk(1'b0, A_ERR,  B_KI,   ALU_NOP,   1'b0, 1'b1);
        endcase
        return w;
    endfunction

    // Per-axis gain slot; axes with no slot read zero
    function automatic logic [GAIN_W-1:0] gain_sel(input logic [GAINS_W-1:0] gains,
                                                   input logic [AXIS_W-1:0] axis);
        logic [GAIN_W-1:0] g;
        case (axis)
            2'd0:    g = gains[15:0];
            2'd1:    g = gains[31:16];
            2'd2:    g = gains[47:32];
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/three_axis_pid_controller_top.sv =====
// ----------------------------------------------------------------------------
// three_axis_pid_controller_top
// Three-axis PID controller, derivative on measurement, run by a small
// microcode program over a shared-multiplier datapath.
// ----------------------------------------------------------------------------
//  channel  | signals                              | role
//  ---------+--------------------------------------+---------------------------
//  in       | in_valid/in_ready, axis, setpoint,   | one word per control sample
//           | measurement                          |
//  out      | out_valid/out_ready, axis_out, drive | clamped drive for the axis
//  cfg      | cfg_wen, cfg_index, cfg_data         | gain/period/limit writes
//
// A word is taken at one edge and then runs eight microcode steps, one a cycle
// but for a hold at the last step, paced by the single shared multiplier (five
// products in sequence): the drive is registered as the last step ends, and the
// next word can be taken as soon as it is. A word whose axis has no loop jumps
// from the first step straight to the last. The result sits in an output
// register, so the next word is taken while it waits; the program only holds at
// its last step if the previous result has not been taken yet. Reset clears the
// integral and last-measurement stores at once and loads the default settings.
// ----------------------------------------------------------------------------
module three_axis_pid_controller_top #(
    parameter int AXES = pid3_pkg::AXES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pid3_pkg::AXIS_W-1:0]         axis,
    input  logic signed [pid3_pkg::DATA_W-1:0]  setpoint,
    input  logic signed [pid3_pkg::DATA_W-1:0]  measurement,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pid3_pkg::AXIS_W-1:0]         axis_out,
    output logic signed [pid3_pkg::DATA_W-1:0]  drive,
    input  logic                                cfg_wen,
    input  logic [pid3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pid3_pkg::GAINS_W-1:0]        cfg_data
);

    // Settings
    logic [pid3_pkg::GAINS_W-1:0] kp_reg;
    logic [pid3_pkg::GAINS_W-1:0] ki_reg;
    logic [pid3_pkg::GAINS_W-1:0] kd_reg;
    logic [pid3_pkg::DATA_W-1:0]  period_reg;
    logic [pid3_pkg::DATA_W-1:0]  rate_reg;
    logic [pid3_pkg::LIM_W-1:0]   ilim_reg;
    logic [pid3_pkg::LIM_W-1:0]   olim_reg;

    // Sequencer and held input word
    logic                                busy_reg;
    logic [pid3_pkg::STEP_W-1:0]         step_reg;
    logic [pid3_pkg::STEP_W-1:0]         step_next;
    logic [pid3_pkg::AXIS_W-1:0]         axis_reg;
    logic signed [pid3_pkg::DATA_W-1:0]  sp_reg;
    logic signed [pid3_pkg::DATA_W-1:0]  ms_reg;

    // Output register
    logic                                out_valid_reg;
    logic [pid3_pkg::AXIS_W-1:0]         axis_out_reg;
    logic signed [pid3_pkg::DATA_W-1:0]  drive_reg;

    pid3_pkg::ctrl_t                     word;
    pid3_pkg::dp_ctl_t                   ctl;
    logic                                axis_ok;
    logic                                out_free;
    logic                                finish;
    logic signed [pid3_pkg::DATA_W-1:0]  drive_res;

    assign in_ready  = !busy_reg;
    assign out_valid = out_valid_reg;
    assign axis_out  = axis_out_reg;
    assign drive     = drive_reg;

    // Microcode fetch and step control
    assign word     = pid3_pkg::ucode(step_reg);
    assign axis_ok  = (32'(axis_reg) < AXES);
    assign out_free = !out_valid_reg || out_ready;
    assign finish   = busy_reg && word.last && out_free;

    always_comb
    begin
        ctl.word    = word;
        ctl.axis_ok = axis_ok;
        ctl.step_en = busy_reg && (!word.last || out_free);
        if (word.jmp_bad && !axis_ok)
            step_next = word.jmp_tgt;
        else
            step_next = step_reg + 1'b1;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= pid3_pkg::KP_RST;
            ki_reg     <= pid3_pkg::KI_RST;
            kd_reg     <= pid3_pkg::KD_RST;
            period_reg <= pid3_pkg::PERIOD_RST;
            rate_reg   <= pid3_pkg::RATE_RST;
            ilim_reg   <= pid3_pkg::ILIM_RST;
            olim_reg   <= pid3_pkg::OLIM_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                pid3_pkg::REG_KP:     kp_reg     <= cfg_data;
                pid3_pkg::REG_KI:     ki_reg     <= cfg_data;
                pid3_pkg::REG_KD:     kd_reg     <= cfg_data;
                pid3_pkg::REG_PERIOD: period_reg <= cfg_data[pid3_pkg::DATA_W-1:0];
                pid3_pkg::REG_RATE:   rate_reg   <= cfg_data[pid3_pkg::DATA_W-1:0];
                pid3_pkg::REG_ILIM:   ilim_reg   <= cfg_data[pid3_pkg::LIM_W-1:0];
                pid3_pkg::REG_OLIM:   olim_reg   <= cfg_data[pid3_pkg::LIM_W-1:0];
                default:              ;
            endcase
        end
    end

    // Sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (finish)
                busy_reg <= 1'b0;
            else if (ctl.step_en)
                step_reg <= step_next;

            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Held input word and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            axis_reg <= axis;
            sp_reg   <= setpoint;
            ms_reg   <= measurement;
        end
        if (finish)
        begin
            axis_out_reg <= axis_reg;
            drive_reg    <= drive_res;
        end
    end

    pid3_dp #(
        .AXES (AXES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .axis           (axis_reg),
        .setpoint       (sp_reg),
        .measurement    (ms_reg),
        .kp             (pid3_pkg::gain_sel(kp_reg, axis_reg)),
        .ki             (pid3_pkg::gain_sel(ki_reg, axis_reg)),
        .kd             (pid3_pkg::gain_sel(kd_reg, axis_reg)),
        .sample_period  (period_reg),
        .sample_rate    (rate_reg),
        .integral_limit (ilim_reg),
        .output_limit   (olim_reg),
        .drive          (drive_res)
    );

endmodule

// ===== rtl/pid3_dp.sv =====
// ----------------------------------------------------------------------------
// pid3_dp
// PID datapath: one shared multiplier, an add/clamp unit and the per-axis
// integral and last-measurement stores, driven by the microcode word.
// ----------------------------------------------------------------------------
module pid3_dp #(
    parameter int AXES = pid3_pkg::AXES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pid3_pkg::dp_ctl_t                 ctl,
    input  logic [pid3_pkg::AXIS_W-1:0]       axis,
    input  logic signed [pid3_pkg::DATA_W-1:0] setpoint,
    input  logic signed [pid3_pkg::DATA_W-1:0] measurement,
    input  logic [pid3_pkg::GAIN_W-1:0]       kp,
    input  logic [pid3_pkg::GAIN_W-1:0]       ki,
    input  logic [pid3_pkg::GAIN_W-1:0]       kd,
    input  logic [pid3_pkg::DATA_W-1:0]       sample_period,
    input  logic [pid3_pkg::DATA_W-1:0]       sample_rate,
    input  logic [pid3_pkg::LIM_W-1:0]        integral_limit,
    input  logic [pid3_pkg::LIM_W-1:0]        output_limit,
    output logic signed [pid3_pkg::DATA_W-1:0] drive
);

    localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

    // Per-axis state
    logic signed [pid3_pkg::INTEG_W-1:0] integ_reg [AXES];
    logic signed [pid3_pkg::DATA_W-1:0]  prev_reg  [AXES];

    // Working registers
    logic signed [pid3_pkg::DIFF_W-1:0]  err_reg;
    logic signed [pid3_pkg::DIFF_W-1:0]  dm_reg;
    logic signed [pid3_pkg::PROD_W-1:0]  prod_reg;
    logic signed [pid3_pkg::ACC_W-1:0]   acc_reg;

    logic [IDX_W-1:0]                     idx;
    logic signed [pid3_pkg::DATA_W-1:0]  prev_rd;
    logic signed [pid3_pkg::INTEG_W-1:0] integ_rd;
    logic signed [pid3_pkg::MA_W-1:0]    mul_a;
    logic signed [pid3_pkg::MB_W-1:0]    mul_b;
    logic signed [pid3_pkg::PROD_W-1:0]  mul_p;
    logic signed [44:0]                  integ_sum;
    logic signed [44:0]                  ilim;
    logic signed [pid3_pkg::INTEG_W-1:0] integ_new;
    logic signed [pid3_pkg::ACC_W-1:0]   prod_sh;
    logic signed [43:0]                  q;
    logic signed [43:0]                  olim;

    function automatic logic signed [pid3_pkg::DIFF_W-1:0] DIFF_EXT(
        input logic signed [pid3_pkg::DATA_W-1:0] v);
        return pid3_pkg::DIFF_W'(v);
    endfunction

    assign idx = IDX_W'(axis);

    // Store read, guarded for axes without a loop
    always_comb
    begin
        prev_rd  = '0;
        integ_rd = '0;
        if (ctl.axis_ok)
        begin
            prev_rd  = prev_reg[idx];
            integ_rd = integ_reg[idx];
        end
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        case (ctl.word.a_sel)
            pid3_pkg::A_ERR:  mul_a = pid3_pkg::MA_W'(err_reg);
            pid3_pkg::A_DM:   mul_a = pid3_pkg::MA_W'(dm_reg);
            pid3_pkg::A_PROD: mul_a = prod_reg[pid3_pkg::MA_W-1:0];
            default:          mul_a = '0;
        endcase
        case (ctl.word.b_sel)
            pid3_pkg::B_KI:   mul_b = {1'b0, ki};
            pid3_pkg::B_KP:   mul_b = {1'b0, kp};
            pid3_pkg::B_KD:   mul_b = {1'b0, kd};
            pid3_pkg::B_PER:  mul_b = {1'b0, sample_period};
            pid3_pkg::B_RATE: mul_b = {1'b0, sample_rate};
            default:          mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Integral update: floor of Q.28 product to Q.20, then symmetric clamp
    always_comb
    begin
        integ_sum = 45'(integ_rd) + 45'(prod_reg >>> 8);
        ilim      = $signed({14'd0, integral_limit, 20'd0});
        if (integ_sum > ilim)
            integ_new = pid3_pkg::INTEG_W'(ilim);
        else if (integ_sum < -ilim)
            integ_new = pid3_pkg::INTEG_W'(-ilim);
        else
            integ_new = integ_sum[pid3_pkg::INTEG_W-1:0];
    end

    assign prod_sh = pid3_pkg::ACC_W'(prod_reg) <<< 8;

    // Output: floor to Q.4, then symmetric clamp; zero for an axis with no loop
    always_comb
    begin
        q    = acc_reg[pid3_pkg::ACC_W-1:16];
        olim = $signed({29'd0, output_limit, 4'd0});
        if (!ctl.axis_ok)
            drive = '0;
        else if (q > olim)
            drive = pid3_pkg::DATA_W'(olim);
        else if (q < -olim)
            drive = pid3_pkg::DATA_W'(-olim);
        else
            drive = q[pid3_pkg::DATA_W-1:0];
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctl.step_en)
        begin
            if (ctl.word.mul_en)
                prod_reg <= mul_p;
            case (ctl.word.alu_op)
                pid3_pkg::ALU_DIFF:
                begin
                    err_reg <= DIFF_EXT(setpoint) - DIFF_EXT(measurement);
                    dm_reg  <= DIFF_EXT(measurement) - DIFF_EXT(prev_rd);
                end
                pid3_pkg::ALU_INTEG: acc_reg <= pid3_pkg::ACC_W'(integ_new);
                pid3_pkg::ALU_ADD:   acc_reg <= acc_reg + prod_sh;
                pid3_pkg::ALU_SUB:   acc_reg <= acc_reg - prod_sh;
                default:             ;
            endcase
        end
    end

    // Per-axis stores, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else if (ctl.step_en && ctl.axis_ok)
        begin
            if (ctl.word.alu_op == pid3_pkg::ALU_INTEG)
                integ_reg[idx] <= integ_new;
            if (ctl.word.alu_op == pid3_pkg::ALU_OUT)
                prev_reg[idx] <= measurement;
        end
    end

endmodule

// ===== test/three_axis_pid_checker.sv =====
// ----------------------------------------------------------------------------
// three_axis_pid_checker
// Watches the input, output and register ports of the three-axis PID
// controller. It keeps its own copy of the settings and of the per-axis
// integral and last measurement, works out the drive for every word taken in,
// and compares each drive word that leaves the block with the oldest one due.
// ----------------------------------------------------------------------------
module three_axis_pid_checker #(
    parameter int AXES = pid3_pkg::AXES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [pid3_pkg::AXIS_W-1:0]         axis,
    input  logic signed [pid3_pkg::DATA_W-1:0]  setpoint,
    input  logic signed [pid3_pkg::DATA_W-1:0]  measurement,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [pid3_pkg::AXIS_W-1:0]         axis_out,
    input  logic signed [pid3_pkg::DATA_W-1:0]  drive,
    input  logic                                cfg_wen,
    input  logic [pid3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pid3_pkg::GAINS_W-1:0]        cfg_data,
    output int                                  mismatches,
    output int                                  drives_pending,
    output int                                  drives_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [pid3_pkg::AXIS_W-1:0]        axis;
        logic signed [pid3_pkg::DATA_W-1:0] drive;
    } drive_word_t;

    drive_word_t                        drive_due[$];

    // Settings copy, loaded as the block sees the writes
    logic [pid3_pkg::GAINS_W-1:0]       kp_gains;
    logic [pid3_pkg::GAINS_W-1:0]       ki_gains;
    logic [pid3_pkg::GAINS_W-1:0]       kd_gains;
    logic [pid3_pkg::DATA_W-1:0]        period;
    logic [pid3_pkg::DATA_W-1:0]        rate;
    logic [pid3_pkg::LIM_W-1:0]         integ_lim;
    logic [pid3_pkg::LIM_W-1:0]         out_lim;

    // Loop state, integral in Q.20 and last measurement in Q.4
    longint                             integ_acc [AXES];
    logic signed [pid3_pkg::DATA_W-1:0] last_meas [AXES];

    int                                 fail_cnt;
    int                                 seen_cnt;

    // Drive for one word; updates the loop state of that axis
    function automatic logic signed [pid3_pkg::DATA_W-1:0] pid_drive(
        input logic [pid3_pkg::AXIS_W-1:0]        a,
        input logic signed [pid3_pkg::DATA_W-1:0] sp,
        input logic signed [pid3_pkg::DATA_W-1:0] ms
    );
        longint kp;
        longint ki;
        longint kd;
        longint err;
        longint integ;
        longint dmeas;
        longint total;
        longint lim;
        longint out;
        if (int'(a) >= AXES)
            return '0;
        // gain slots above bit 47 read as zero
        kp = (a < 3) ? longint'(kp_gains[16*a +: 16]) : 0;
        ki = (a < 3) ? longint'(ki_gains[16*a +: 16]) : 0;
        kd = (a < 3) ? longint'(kd_gains[16*a +: 16]) : 0;

        err = longint'(sp) - longint'(ms);

        // integral: Q.28 product floored to Q.20, then clamped
        integ = integ_acc[a] + ((ki * err * longint'(period)) >>> 8);
        lim = longint'(integ_lim) <<< 20;
        if (integ > lim)
            integ = lim;
        else if (integ < -lim)
            integ = -lim;
        integ_acc[a] = integ;

        // derivative on measurement, all summed in Q.20
        dmeas = (longint'(ms) - longint'(last_meas[a])) * longint'(rate);
        total = kp * err * 256 + integ - kd * dmeas * 256;
        out = total >>> 16;
        lim = longint'(out_lim) <<< 4;
        if (out > lim)
            out = lim;
        else if (out < -lim)
            out = -lim;

        last_meas[a] = ms;
        return out[pid3_pkg::DATA_W-1:0];
    endfunction

    // Watch all three ports at each edge
    always @(posedge clk or negedge rst_n)
    begin
        drive_word_t want;
        if (!rst_n)
        begin
            kp_gains  = pid3_pkg::KP_RST;
            ki_gains  = pid3_pkg::KI_RST;
            kd_gains  = pid3_pkg::KD_RST;
            period    = pid3_pkg::PERIOD_RST;
            rate      = pid3_pkg::RATE_RST;
            integ_lim = pid3_pkg::ILIM_RST;
            out_lim   = pid3_pkg::OLIM_RST;
            for (int i = 0; i < AXES; i++)
            begin
                integ_acc[i] = 0;
                last_meas[i] = '0;
            end
            drive_due.delete();
            fail_cnt = 0;
            seen_cnt = 0;
            mismatches     <= 0;
            drives_pending <= 0;
            drives_checked <= 0;
        end
        else
        begin
            // register writes; narrow registers keep their low bits only
            if (cfg_wen)
            begin
                case (cfg_index)
                    pid3_pkg::REG_KP:     kp_gains  = cfg_data;
                    pid3_pkg::REG_KI:     ki_gains  = cfg_data;
                    pid3_pkg::REG_KD:     kd_gains  = cfg_data;
                    pid3_pkg::REG_PERIOD: period    = cfg_data[pid3_pkg::DATA_W-1:0];
                    pid3_pkg::REG_RATE:   rate      = cfg_data[pid3_pkg::DATA_W-1:0];
                    pid3_pkg::REG_ILIM:   integ_lim = cfg_data[pid3_pkg::LIM_W-1:0];
                    pid3_pkg::REG_OLIM:   out_lim   = cfg_data[pid3_pkg::LIM_W-1:0];
                    default:              ;
                endcase
            end

            // drive word leaving the block
            if (out_valid && out_ready)
            begin
                if (drive_due.size() == 0)
                begin
                    fail_cnt++;
                    $error("drive word with none due: axis_out %0d drive %0d",
                           axis_out, drive);
                end
                else
                begin
                    want = drive_due.pop_front();
                    seen_cnt++;
                    if (axis_out !== want.axis)
                    begin
                        fail_cnt++;
                        $error("axis_out: expected %0d, got %0d",
                               want.axis, axis_out);
                    end
                    if (drive !== want.drive)
                    begin
                        fail_cnt++;
                        $error("drive (axis %0d): expected %0d, got %0d",
                               want.axis, want.drive, drive);
                    end
                end
            end

            // word taken in: work out its drive now
            if (in_valid && in_ready)
            begin
                want.axis  = axis;
                want.drive = pid_drive(axis, setpoint, measurement);
                drive_due.push_back(want);
            end

            mismatches     <= fail_cnt;
            drives_pending <= drive_due.size();
            drives_checked <= seen_cnt;
        end
    end

endmodule

// ===== test/three_axis_pid_controller_top_tb.sv =====
// ----------------------------------------------------------------------------
// three_axis_pid_controller_top_tb
// Drives the three-axis PID controller with directed and random words under
// several gain, period and limit settings, with random stalls on both sides;
// the checker beside the block predicts and compares every drive word.
// ----------------------------------------------------------------------------
module three_axis_pid_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Axis with no loop behind it, and a register index nothing answers to
    localparam logic [pid3_pkg::AXIS_W-1:0]    NO_LOOP_AXIS = 2'd3;
    localparam logic [pid3_pkg::CFG_IDX_W-1:0] REG_NONE     = 3'd7;

    localparam logic signed [pid3_pkg::DATA_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [pid3_pkg::DATA_W-1:0] S_MIN = 16'sh8000;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic [pid3_pkg::AXIS_W-1:0]         axis;
    logic signed [pid3_pkg::DATA_W-1:0]  setpoint;
    logic signed [pid3_pkg::DATA_W-1:0]  measurement;
    logic                                out_valid;
    logic                                out_ready;
    logic [pid3_pkg::AXIS_W-1:0]         axis_out;
    logic signed [pid3_pkg::DATA_W-1:0]  drive;
    logic                                cfg_wen;
    logic [pid3_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [pid3_pkg::GAINS_W-1:0]        cfg_data;

    int                        mismatches;
    int                        drives_pending;
    int                        drives_checked;

    bit                        idle_on;
    int                        words_sent;
    int                        no_loop_sent;
    int                        settings_used;

    three_axis_pid_controller_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .axis        (axis),
        .setpoint    (setpoint),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .axis_out    (axis_out),
        .drive       (drive),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    three_axis_pid_checker drive_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .axis           (axis),
        .setpoint       (setpoint),
        .measurement    (measurement),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .axis_out       (axis_out),
        .drive          (drive),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .drives_pending (drives_pending),
        .drives_checked (drives_checked)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // Receiver: stalls about 27 percent of the time while idling is on
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= !idle_on || ($urandom_range(0, 99) >= 27);
        end
    end

    // Offer one word, after a random gap, and hold it until taken
    task automatic push_word(input logic [pid3_pkg::AXIS_W-1:0]        a,
                             input logic signed [pid3_pkg::DATA_W-1:0] sp,
                             input logic signed [pid3_pkg::DATA_W-1:0] ms);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 27)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        axis        <= a;
        setpoint    <= sp;
        measurement <= ms;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (a == NO_LOOP_AXIS)
            no_loop_sent++;
    endtask

    function automatic logic signed [pid3_pkg::DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return -16'sd1;
        endcase
    endfunction

    // Mostly realistic loop traffic, some full-range and corner values
    task automatic random_word();
        logic [pid3_pkg::AXIS_W-1:0]        a;
        logic signed [pid3_pkg::DATA_W-1:0] sp;
        logic signed [pid3_pkg::DATA_W-1:0] ms;
        int                                 base;
        a = ($urandom_range(0, 99) < 8) ? NO_LOOP_AXIS
                                        : pid3_pkg::AXIS_W'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0, 1:
            begin
                sp = pid3_pkg::DATA_W'($urandom);
                ms = pid3_pkg::DATA_W'($urandom);
            end
            2:
            begin
                sp = pick_extreme();
                ms = pick_extreme();
            end
            default:
            begin
                base = int'($urandom_range(0, 1600)) - 800;
                sp = pid3_pkg::DATA_W'(base);
                ms = pid3_pkg::DATA_W'(base + int'($urandom_range(0, 96)) - 48);
            end
        endcase
        push_word(a, sp, ms);
    endtask

    // Let every drive word out, then give the block time to go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (drives_pending != 0);
        repeat (12) @(posedge clk);
    endtask

    // Write all seven registers and one unused index; junk fills the
    // unused upper bits of the narrow registers when asked
    task automatic load_settings(input logic [pid3_pkg::GAINS_W-1:0] kp,
                                 input logic [pid3_pkg::GAINS_W-1:0] ki,
                                 input logic [pid3_pkg::GAINS_W-1:0] kd,
                                 input logic [pid3_pkg::DATA_W-1:0]  per,
                                 input logic [pid3_pkg::DATA_W-1:0]  rt,
                                 input logic [pid3_pkg::LIM_W-1:0]   ilim,
                                 input logic [pid3_pkg::LIM_W-1:0]   olim,
                                 input bit                           junk);
        logic [pid3_pkg::CFG_IDX_W-1:0] idx [8];
        logic [pid3_pkg::GAINS_W-1:0]   val [8];
        logic [pid3_pkg::GAINS_W-1:0]   fill;
        fill = junk ? pid3_pkg::GAINS_W'({$urandom, $urandom}) : '0;
        idx = '{pid3_pkg::REG_KP, pid3_pkg::REG_KI, pid3_pkg::REG_KD,
                pid3_pkg::REG_PERIOD, pid3_pkg::REG_RATE, pid3_pkg::REG_ILIM,
                pid3_pkg::REG_OLIM, REG_NONE};
        val[0] = kp;
        val[1] = ki;
        val[2] = kd;
        val[3] = {fill[pid3_pkg::GAINS_W-1:pid3_pkg::DATA_W], per};
        val[4] = {fill[pid3_pkg::GAINS_W-1:pid3_pkg::DATA_W], rt};
        val[5] = {fill[pid3_pkg::GAINS_W-1:pid3_pkg::LIM_W], ilim};
        val[6] = {fill[pid3_pkg::GAINS_W-1:pid3_pkg::LIM_W], olim};
        val[7] = pid3_pkg::GAINS_W'({$urandom, $urandom});
        for (int i = 0; i < 8; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    // Per-axis Q8.8 gains: mostly modest, now and then anything
    function automatic logic [pid3_pkg::GAINS_W-1:0] random_gains();
        logic [pid3_pkg::GAINS_W-1:0] g;
        for (int i = 0; i < 3; i++)
            g[16*i +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 16'h1400));
        return g;
    endfunction

    // Stimulus
    initial
    begin
        logic [pid3_pkg::DATA_W-1:0] per;
        logic [pid3_pkg::DATA_W-1:0] rt;
        int                          guard;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        axis          = '0;
        setpoint      = '0;
        measurement   = '0;
        cfg_wen       = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        idle_on       = 1'b1;
        words_sent    = 0;
        no_loop_sent  = 0;
        settings_used = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings from reset: signs, largest error, derivative swings,
        // the axis with no loop, and the integral driven into both clamps
        push_word(2'd0, 16'sd0, 16'sd0);
        push_word(2'd0, 16'sd160, 16'sd0);
        push_word(2'd1, -16'sd160, 16'sd0);
        push_word(2'd2, S_MAX, S_MIN);
        push_word(2'd2, S_MIN, S_MAX);
        push_word(2'd0, 16'sd0, S_MAX);
        push_word(2'd0, 16'sd0, S_MIN);
        push_word(2'd1, 16'sd100, 16'sd100);
        push_word(NO_LOOP_AXIS, 16'sd1234, -16'sd77);
        push_word(NO_LOOP_AXIS, S_MAX, S_MIN);
        repeat (4) push_word(2'd1, S_MAX, S_MIN);
        repeat (4) push_word(2'd1, S_MIN, S_MAX);

        // Everything at its top value
        settle();
        load_settings({pid3_pkg::GAINS_W{1'b1}}, {pid3_pkg::GAINS_W{1'b1}},
                      {pid3_pkg::GAINS_W{1'b1}},
                      16'hFFFF, 16'hFFFF, 11'h7FF, 11'h7FF, 1'b0);
        push_word(2'd0, S_MAX, S_MIN);
        push_word(2'd1, S_MIN, S_MAX);
        push_word(2'd2, S_MAX, S_MAX);
        push_word(NO_LOOP_AXIS, S_MIN, S_MIN);

        // Everything zero: no period, no rate, clamps shut
        settle();
        load_settings('0, '0, '0, '0, '0, '0, '0, 1'b0);
        push_word(2'd0, S_MAX, S_MIN);
        push_word(2'd2, S_MIN, S_MAX);
        push_word(2'd1, 16'sd300, -16'sd300);
        repeat (30) random_word();

        // Random settings; one phase runs with no idling on either side
        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            per = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(1, 1024));
            rt  = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(1, 1000));
            load_settings(random_gains(), random_gains(), random_gains(), per, rt,
                          11'($urandom), 11'($urandom), phase[0]);
            idle_on = (phase != 2);
            repeat (165) random_word();
        end
        idle_on = 1'b1;

        // Drain, with a bound
        in_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (drives_pending != 0 && guard < 20000);
        repeat (16) @(posedge clk);

        if (drives_pending != 0)
            $error("%0d drive words never came out", drives_pending);
        $display("run: %0d words over %0d register settings, %0d on the loopless axis",
                 words_sent, settings_used, no_loop_sent);
        $display("run: %0d drive words compared, %0d mismatches",
                 drives_checked, mismatches);
        if (mismatches == 0 && drives_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pid3_pkg.sv
rtl/pid3_dp.sv
rtl/three_axis_pid_controller_top.sv
test/three_axis_pid_checker.sv
test/three_axis_pid_controller_top_tb.sv
